### rtl/brw_pkg.sv
// Shared types and constants for the bicubic resample weight generator.
// Used by every module in rtl/. No dependencies.
package brw_pkg;

    localparam int TI_W    = 6;   // target index
    localparam int IDX_W   = 6;   // source index
    localparam int LEN_W   = 7;   // source_length register
    localparam int INV_W   = 24;  // inverse_scale register, Q16
    localparam int PROD_W  = 31;  // (2*ti+1) * inverse_scale
    localparam int POS_W   = 32;  // signed source position, Q16
    localparam int FL_W    = 16;  // floor(position)
    localparam int U_W     = 18;  // unclamped tap index
    localparam int DIST_W  = 18;  // tap distance, Q16, 0..131072
    localparam int SQ_W    = 35;  // distance squared
    localparam int CUBE_W  = 52;  // distance cubed
    localparam int NUM_W   = 58;  // cubic numerator, Q48 scaled by 4
    localparam int RND_SH  = 34;  // numerator to Q16 weight
    localparam int TAPW_W  = 19;  // one tap weight, signed Q16
    localparam int SUM_W   = 21;  // merged weight before saturation
    localparam int WGT_W   = 19;  // result weight
    localparam int NTAPS   = 4;
    localparam int PTR_W   = 2;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    localparam logic [LEN_W-1:0]  LEN_RST   = 7'd37;
    localparam logic [INV_W-1:0]  INV_RST   = 24'd65536;
    localparam logic [LEN_W-1:0]  LEN_LIMIT = 7'd64;
    localparam logic [IDX_W-1:0]  IDX_MAX   = 6'd63;

    localparam logic [DIST_W-1:0] ONE_Q16 = 18'd65536;
    localparam logic [DIST_W-1:0] TWO_Q16 = 18'd131072;
    localparam logic signed [POS_W-1:0] HALF_Q16 = 32'sd32768;

    // constant terms of the two cubic pieces and the rounding offset
    localparam logic signed [NUM_W-1:0] NEAR_K  = 58'sh4000000000000;  // 4 * 2^48
    localparam logic signed [NUM_W-1:0] FAR_K   = 58'shC000000000000;  // 12 * 2^48
    localparam logic signed [NUM_W-1:0] ROUND_K = 58'sh200000000;      // 2^33

    localparam logic signed [SUM_W-1:0] SUM_MAX = 21'sd262143;
    localparam logic signed [SUM_W-1:0] SUM_MIN = -21'sd262144;

    typedef enum logic {
        REG_SRC_LEN   = 1'b0,
        REG_INV_SCALE = 1'b1
    } t_reg;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] tap_d;
    } t_tap;

    typedef struct packed {
        logic [IDX_W-1:0]         idx;
        logic signed [TAPW_W-1:0] wgt;
    } t_wtap;

    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic signed [WGT_W-1:0] wgt;
    } t_res;

endpackage

### rtl/bicubic_resample_weight_generator_core.sv
// Bicubic resample weight generator: top level with the register port,
// the pipeline valid chain and assertions. Depends on brw_pkg, brw_pos,
// brw_cubic and brw_merge.
//
// Use: write source_length (byte address 0) and inverse_scale (byte address 4)
// over the APB port while the block is idle, then send target indices on the
// i_valid/o_ready request channel. Each request yields one to four results on
// the o_valid/i_ready channel, in ascending source index order, with o_last on
// the final one for that target index.
// Path: a request passes two position stages, three cubic stages and one
// serializer register before its first result is valid; the first of them
// loads on the accepting edge.
// Throughput: a request enters every cycle while the pipeline moves; the
// result serializer sends one result per cycle while i_ready is high, and a
// request has 1 to 4 results, 4 in the usual case.
// Reset: synchronous, active low; clears the pipeline valids and the
// serializer and loads source_length = 37, inverse_scale = 1.0.
// Stall: while the receiver holds i_ready low, the whole pipeline holds
// once its last stage is full, and o_ready drops; nothing is lost.
module bicubic_resample_weight_generator_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [brw_pkg::ADDR_W-1:0]         paddr,
    input  logic [brw_pkg::DATA_W-1:0]         pwdata,
    output logic [brw_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    // request channel
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [brw_pkg::TI_W-1:0]           i_target_index,
    // result channel
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [brw_pkg::IDX_W-1:0]          o_source_index,
    output logic signed [brw_pkg::WGT_W-1:0]   o_weight,
    output logic                               o_last
);

    localparam int NSTG = 5;

    logic [brw_pkg::LEN_W-1:0]          r_len;
    logic [brw_pkg::INV_W-1:0]          r_inv;
    logic                               w_wr;
    brw_pkg::t_reg                      w_reg;
    logic [NSTG-1:0]                    r_vld;
    logic                               w_adv;
    logic                               w_mrg_ready;
    brw_pkg::t_tap  [brw_pkg::NTAPS-1:0] w_tap;
    brw_pkg::t_wtap [brw_pkg::NTAPS-1:0] w_wtap;

    // register port
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_reg  = brw_pkg::t_reg'(paddr[2]);

    always_comb begin
        unique case (w_reg)
            brw_pkg::REG_SRC_LEN:
                prdata = {{(brw_pkg::DATA_W-brw_pkg::LEN_W){1'b0}}, r_len};
            brw_pkg::REG_INV_SCALE:
                prdata = {{(brw_pkg::DATA_W-brw_pkg::INV_W){1'b0}}, r_inv};
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= brw_pkg::LEN_RST;
            r_inv <= brw_pkg::INV_RST;
        end else if (w_wr) begin
            unique case (w_reg)
                brw_pkg::REG_SRC_LEN:   r_len <= pwdata[brw_pkg::LEN_W-1:0];
                brw_pkg::REG_INV_SCALE: r_inv <= pwdata[brw_pkg::INV_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline moves as a whole unless its last stage is full and blocked
    assign w_adv   = !r_vld[NSTG-1] || w_mrg_ready;
    assign o_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    brw_pos u_pos (
        .i_clk          (i_clk),
        .i_en           (w_adv),
        .i_target_index (i_target_index),
        .i_len          (r_len),
        .i_inv          (r_inv),
        .o_tap          (w_tap)
    );

    for (genvar g = 0; g < brw_pkg::NTAPS; g++) begin : g_lane
        brw_cubic u_cubic (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_tap  (w_tap[g]),
            .o_wtap (w_wtap[g])
        );
    end

    brw_merge u_merge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (r_vld[NSTG-1]),
        .i_wtap         (w_wtap),
        .o_ready        (w_mrg_ready),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_source_index (o_source_index),
        .o_weight       (o_weight),
        .o_last         (o_last)
    );

    // a request's results follow one another without gaps
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last) |=> o_valid)
        else $error("result train broken before last");

    // merged indices come out strictly ascending within a request
    a_ascend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last) |=> (o_source_index > $past(o_source_index)))
        else $error("source index not ascending");

    // no result appears without a request reaching the serializer
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last && !r_vld[NSTG-1]) |=> !o_valid)
        else $error("result without request");

endmodule

### rtl/brw_pos.sv
// Source position stages: position multiply, then floor/fraction, clamped tap
// indices and tap distances. Depends on brw_pkg.
module brw_pos (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic [brw_pkg::TI_W-1:0]              i_target_index,
    input  logic [brw_pkg::LEN_W-1:0]             i_len,
    input  logic [brw_pkg::INV_W-1:0]             i_inv,
    output brw_pkg::t_tap [brw_pkg::NTAPS-1:0]    o_tap
);

    logic [brw_pkg::PROD_W-1:0]         r_prod;
    logic [brw_pkg::PROD_W-1:0]         n_prod;
    logic signed [brw_pkg::POS_W-1:0]   w_pos;
    logic signed [brw_pkg::FL_W:0]      w_first;
    logic [brw_pkg::DIST_W-1:0]         w_frac;
    logic [brw_pkg::IDX_W-1:0]          w_len_m1;
    logic signed [brw_pkg::U_W-1:0]     w_u [brw_pkg::NTAPS];
    brw_pkg::t_tap [brw_pkg::NTAPS-1:0] r_tap;
    brw_pkg::t_tap [brw_pkg::NTAPS-1:0] n_tap;

    assign n_prod = {{(brw_pkg::PROD_W-brw_pkg::TI_W-1){1'b0}}, i_target_index, 1'b1}
                  * {{(brw_pkg::PROD_W-brw_pkg::INV_W){1'b0}}, i_inv};

    always_comb begin
        // position = floor((2*ti+1)*inv/2) - 0.5
        w_pos   = $signed({2'b00, r_prod[brw_pkg::PROD_W-1:1]}) - brw_pkg::HALF_Q16;
        w_first = $signed({w_pos[brw_pkg::POS_W-1], w_pos[brw_pkg::POS_W-1 -: brw_pkg::FL_W]})
                - $signed((brw_pkg::FL_W+1)'(1));
        w_frac  = {2'b00, w_pos[15:0]};

        if (i_len == '0) begin
            w_len_m1 = '0;
        end else if (i_len >= brw_pkg::LEN_LIMIT) begin
            w_len_m1 = brw_pkg::IDX_MAX;
        end else begin
            w_len_m1 = i_len[brw_pkg::IDX_W-1:0] - brw_pkg::IDX_W'(1);
        end

        for (int k = 0; k < brw_pkg::NTAPS; k++) begin
            w_u[k] = $signed({w_first[brw_pkg::FL_W], w_first}) + $signed(brw_pkg::U_W'(k));
            if (w_u[k] < 0) begin
                n_tap[k].idx = '0;
            end else if (w_u[k] > $signed({{(brw_pkg::U_W-brw_pkg::IDX_W){1'b0}}, w_len_m1}))
            begin
                n_tap[k].idx = w_len_m1;
            end else begin
                n_tap[k].idx = w_u[k][brw_pkg::IDX_W-1:0];
            end
        end

        n_tap[0].tap_d = brw_pkg::ONE_Q16 + w_frac;
        n_tap[1].tap_d = w_frac;
        n_tap[2].tap_d = brw_pkg::ONE_Q16 - w_frac;
        n_tap[3].tap_d = brw_pkg::TWO_Q16 - w_frac;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_tap  <= n_tap;
        end
    end

    assign o_tap = r_tap;

endmodule

### rtl/brw_cubic.sv
// One Keys cubic lane (a = -0.75): square, cube, then numerator and rounding.
// Three register stages. Depends on brw_pkg.
module brw_cubic (
    input  logic           i_clk,
    input  logic           i_en,
    input  brw_pkg::t_tap  i_tap,
    output brw_pkg::t_wtap o_wtap
);

    localparam int SQP_W = 2 * brw_pkg::DIST_W;
    localparam int CBP_W = brw_pkg::SQ_W + brw_pkg::DIST_W;

    // stage A: square
    logic [SQP_W-1:0]             w_sq;
    logic [brw_pkg::SQ_W-1:0]     r_d2;
    brw_pkg::t_tap                r_a;
    // stage B: cube and the lower-order terms
    logic [CBP_W-1:0]             w_cube;
    logic signed [brw_pkg::NUM_W-1:0] w_d2s, w_ds, w_nine, w_fift, w_tw4, n_pre;
    logic [brw_pkg::CUBE_W-1:0]   r_d3;
    logic signed [brw_pkg::NUM_W-1:0] r_pre;
    logic                         r_near, r_zero;
    logic [brw_pkg::IDX_W-1:0]    r_b_idx;
    // stage C: cubic term, rounding
    logic signed [brw_pkg::NUM_W-1:0] w_c, w_cterm, w_num;
    brw_pkg::t_wtap               r_w, n_w;

    assign w_sq   = {{brw_pkg::DIST_W{1'b0}}, i_tap.tap_d}
                  * {{brw_pkg::DIST_W{1'b0}}, i_tap.tap_d};
    assign w_cube = {{brw_pkg::DIST_W{1'b0}}, r_d2}
                  * {{brw_pkg::SQ_W{1'b0}}, r_a.tap_d};

    always_comb begin
        w_d2s  = $signed({{(brw_pkg::NUM_W-brw_pkg::SQ_W){1'b0}}, r_d2});
        w_ds   = $signed({{(brw_pkg::NUM_W-brw_pkg::DIST_W){1'b0}}, r_a.tap_d});
        w_nine = (w_d2s <<< 3) + w_d2s;
        w_fift = (w_d2s <<< 4) - w_d2s;
        w_tw4  = (w_ds <<< 4) + (w_ds <<< 3);
        if (r_a.tap_d <= brw_pkg::ONE_Q16) begin
            // 1.25 d^3 - 2.25 d^2 + 1, scaled by 4
            n_pre = brw_pkg::NEAR_K - (w_nine <<< 16);
        end else begin
            // -0.75 d^3 + 3.75 d^2 - 6 d + 3, scaled by 4
            n_pre = brw_pkg::FAR_K + (w_fift <<< 16) - (w_tw4 <<< 32);
        end
    end

    always_comb begin
        w_c     = $signed({{(brw_pkg::NUM_W-brw_pkg::CUBE_W){1'b0}}, r_d3});
        w_cterm = r_near ? ((w_c <<< 2) + w_c) : -((w_c <<< 1) + w_c);
        w_num   = w_cterm + r_pre + brw_pkg::ROUND_K;
        n_w.idx = r_b_idx;
        // arithmetic shift by 34 rounds to nearest, ties up, after the offset
        n_w.wgt = r_zero ? '0 : w_num[brw_pkg::RND_SH +: brw_pkg::TAPW_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d2    <= w_sq[brw_pkg::SQ_W-1:0];
            r_a     <= i_tap;
            r_d3    <= w_cube[brw_pkg::CUBE_W-1:0];
            r_pre   <= n_pre;
            r_near  <= (r_a.tap_d <= brw_pkg::ONE_Q16);
            r_zero  <= (r_a.tap_d >= brw_pkg::TWO_Q16);
            r_b_idx <= r_a.idx;
            r_w     <= n_w;
        end
    end

    assign o_wtap = r_w;

endmodule

### rtl/brw_merge.sv
// Merge of taps that clamp to one index, saturation, and the result serializer
// that sends one (index, weight) result per cycle while taken. Depends on brw_pkg.
module brw_merge (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  brw_pkg::t_wtap [brw_pkg::NTAPS-1:0]   i_wtap,
    output logic                                  o_ready,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [brw_pkg::IDX_W-1:0]             o_source_index,
    output logic signed [brw_pkg::WGT_W-1:0]      o_weight,
    output logic                                  o_last
);

    logic [brw_pkg::NTAPS-1:0]          w_start;
    logic signed [brw_pkg::SUM_W-1:0]   w_gsum [brw_pkg::NTAPS];
    logic [brw_pkg::PTR_W:0]            w_cnt;
    brw_pkg::t_res                      w_res;
    brw_pkg::t_res [brw_pkg::NTAPS-1:0] n_ent, r_ent;
    logic [brw_pkg::PTR_W-1:0]          n_lastp, r_lastp, r_ptr;
    logic                               r_valid;
    logic                               w_load, w_take;

    always_comb begin
        w_start[0] = 1'b1;
        for (int k = 1; k < brw_pkg::NTAPS; k++) begin
            w_start[k] = (i_wtap[k].idx != i_wtap[k-1].idx);
        end

        // sum of each run of equal indices, taken at the run's first tap
        w_gsum[brw_pkg::NTAPS-1] = brw_pkg::SUM_W'(i_wtap[brw_pkg::NTAPS-1].wgt);
        for (int k = brw_pkg::NTAPS - 2; k >= 0; k--) begin
            w_gsum[k] = brw_pkg::SUM_W'(i_wtap[k].wgt)
                      + (w_start[k+1] ? '0 : w_gsum[k+1]);
        end

        n_ent = r_ent;
        w_cnt = '0;
        w_res = '0;
        for (int k = 0; k < brw_pkg::NTAPS; k++) begin
            w_res.idx = i_wtap[k].idx;
            if (w_gsum[k] > brw_pkg::SUM_MAX) begin
                w_res.wgt = brw_pkg::SUM_MAX[brw_pkg::WGT_W-1:0];
            end else if (w_gsum[k] < brw_pkg::SUM_MIN) begin
                w_res.wgt = brw_pkg::SUM_MIN[brw_pkg::WGT_W-1:0];
            end else begin
                w_res.wgt = w_gsum[k][brw_pkg::WGT_W-1:0];
            end
            if (w_start[k]) begin
                n_ent[w_cnt[brw_pkg::PTR_W-1:0]] = w_res;
                w_cnt = w_cnt + 1'b1;
            end
        end
        n_lastp = w_cnt[brw_pkg::PTR_W-1:0] - 1'b1;
    end

    assign o_valid        = r_valid;
    assign o_source_index = r_ent[r_ptr].idx;
    assign o_weight       = r_ent[r_ptr].wgt;
    assign o_last         = (r_ptr == r_lastp);
    assign w_take         = r_valid && i_ready;
    assign o_ready        = !r_valid || (i_ready && o_last);
    assign w_load         = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ptr   <= '0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_ptr   <= '0;
            end else if (w_take) begin
                if (o_last) begin
                    r_valid <= 1'b0;
                    r_ptr   <= '0;
                end else begin
                    r_ptr <= r_ptr + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ent   <= n_ent;
            r_lastp <= n_lastp;
        end
    end

endmodule
